@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/kcat_pkg.sv @@
package kcat_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BITS_DEF    = 16;
   localparam int VALUE_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_ACCUM,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [KEY_W-1:0]   item_key;
      logic [VALUE_W-1:0] item_value;
      logic [SLOT_W-1:0]  read_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  out_slot;
      logic [KEY_W-1:0]   out_key;
      logic [VALUE_W-1:0] out_value;
      logic               was_present;
      logic               dropped;
      logic               slot_valid;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [KEY_W-1:0]   item_key;
      logic [VALUE_W-1:0] item_value;
      logic [SLOT_W-1:0]  read_slot;
   } cmd_type;

endpackage

@@ hw/rtl/kcat_front.sv @@
module kcat_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kcat_pkg::req_type req_data,
   output logic              push,
   output kcat_pkg::cmd_type push_cmd,
   input  logic              q_full
);

   logic              front_valid_ff;
   logic              front_valid_in;
   kcat_pkg::cmd_type front_cmd_ff;
   kcat_pkg::cmd_type front_cmd_in;
   logic              accept;

   assign req_stall = front_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !q_full;
   assign push_cmd  = front_cmd_ff;

   // decode the op into a command kind for the back end
   always_comb begin
      front_cmd_in            = front_cmd_ff;
      front_valid_in          = front_valid_ff;
      if (accept) begin
         front_valid_in          = 1'b1;
         front_cmd_in.item_key   = req_data.item_key;
         front_cmd_in.item_value = req_data.item_value;
         front_cmd_in.read_slot  = req_data.read_slot;
         unique case (req_data.op)
            kcat_pkg::OP_CLEAR: front_cmd_in.kind = kcat_pkg::CMD_CLEAR;
            kcat_pkg::OP_ACCUM: front_cmd_in.kind = kcat_pkg::CMD_ACCUM;
            kcat_pkg::OP_READ:  front_cmd_in.kind = kcat_pkg::CMD_READ;
            kcat_pkg::OP_NONE:  front_cmd_in.kind = kcat_pkg::CMD_NOP;
         endcase
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_cmd_ff <= front_cmd_in;
   end

endmodule

@@ hw/rtl/kcat_queue.sv @@
module kcat_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kcat_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output kcat_pkg::cmd_type head_cmd
);

   localparam int Depth = kcat_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(Depth);
   localparam int CNTW  = $clog2(Depth + 1);

   kcat_pkg::cmd_type entries_ff [Depth];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [CNTW-1:0]   count_ff;
   logic [CNTW-1:0]   count_in;

   assign full       = (count_ff == CNTW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (push) begin
            entries_ff[wr_ptr_ff] <= push_cmd;
         end
      end
   end

endmodule

@@ hw/rtl/kcat_back.sv @@
`include "assert_macros.svh"

module kcat_back #(
   parameter int TABLE_DEPTH = kcat_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = kcat_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS  = kcat_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  kcat_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kcat_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = KEY_BITS + VALUE_BITS;
   localparam int SW = (CW > kcat_pkg::SLOT_W) ? CW : kcat_pkg::SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ
   } state_type;

   // table storage, key in the upper bits
   logic [EW-1:0]     mem [TABLE_DEPTH];
   logic [EW-1:0]     rd_data_ff;
   logic [AW-1:0]     raddr;
   logic              mem_we;
   logic [AW-1:0]     waddr;
   logic [EW-1:0]     wdata;

   state_type         state_ff;
   state_type         state_in;
   kcat_pkg::cmd_type cmd_ff;
   kcat_pkg::cmd_type cmd_in;
   logic [CW-1:0]     used_ff;
   logic [CW-1:0]     used_in;
   logic [AW-1:0]     idx_ff;
   logic [AW-1:0]     idx_in;
   logic              rsp_valid_ff;
   kcat_pkg::rsp_type rsp_ff;
   kcat_pkg::rsp_type rsp_in;
   logic              load_rsp;

   kcat_pkg::cmd_type act_cmd;
   logic              out_free;
   logic              do_append;
   logic [KEY_BITS-1:0]   acc_key;
   logic [VALUE_BITS-1:0] acc_val;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [VALUE_BITS:0]   sum_wide;
   logic [VALUE_BITS-1:0] sum_sat;
   logic [CW-1:0]         nxt_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign act_cmd   = (state_ff == ST_IDLE) ? q_cmd : cmd_ff;
   assign acc_key   = KEY_BITS'(act_cmd.item_key);
   assign acc_val   = VALUE_BITS'(act_cmd.item_value);
   assign rd_key    = rd_data_ff[EW-1:VALUE_BITS];
   assign rd_val    = rd_data_ff[VALUE_BITS-1:0];
   assign sum_wide  = {1'b0, rd_val} + {1'b0, acc_val};
   assign sum_sat   = sum_wide[VALUE_BITS] ? '1 : sum_wide[VALUE_BITS-1:0];
   assign nxt_idx   = CW'(idx_ff) + CW'(1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      raddr     = '0;
      mem_we    = 1'b0;
      waddr     = '0;
      wdata     = '0;
      load_rsp  = 1'b0;
      rsp_in    = '0;
      q_pop     = 1'b0;
      do_append = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.kind)
                  kcat_pkg::CMD_CLEAR: begin
                     used_in  = '0;
                     load_rsp = 1'b1;
                  end
                  kcat_pkg::CMD_NOP: begin
                     load_rsp           = 1'b1;
                     rsp_in.entry_count = kcat_pkg::COUNT_W'(used_ff);
                  end
                  kcat_pkg::CMD_READ: begin
                     if (SW'(q_cmd.read_slot) < SW'(used_ff)) begin
                        raddr    = AW'(q_cmd.read_slot);
                        state_in = ST_READ;
                     end else begin
                        load_rsp           = 1'b1;
                        rsp_in.out_slot    = q_cmd.read_slot;
                        rsp_in.entry_count = kcat_pkg::COUNT_W'(used_ff);
                     end
                  end
                  kcat_pkg::CMD_ACCUM: begin
                     if (used_ff == '0) begin
                        do_append = 1'b1;
                     end else begin
                        raddr    = '0;
                        idx_in   = '0;
                        state_in = ST_SEARCH;
                     end
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // compare entry idx while the next one is being fetched
            priority if (rd_key == acc_key) begin
               mem_we             = 1'b1;
               waddr              = idx_ff;
               wdata              = {acc_key, sum_sat};
               load_rsp           = 1'b1;
               rsp_in.out_slot    = kcat_pkg::SLOT_W'(idx_ff);
               rsp_in.out_key     = kcat_pkg::KEY_W'(acc_key);
               rsp_in.out_value   = kcat_pkg::VALUE_W'(sum_sat);
               rsp_in.was_present = 1'b1;
               rsp_in.slot_valid  = 1'b1;
               rsp_in.entry_count = kcat_pkg::COUNT_W'(used_ff);
               state_in           = ST_IDLE;
            end else if (nxt_idx < used_ff) begin
               raddr  = nxt_idx[AW-1:0];
               idx_in = nxt_idx[AW-1:0];
            end else begin
               do_append = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            load_rsp           = 1'b1;
            rsp_in.out_slot    = cmd_ff.read_slot;
            rsp_in.out_key     = kcat_pkg::KEY_W'(rd_key);
            rsp_in.out_value   = kcat_pkg::VALUE_W'(rd_val);
            rsp_in.slot_valid  = 1'b1;
            rsp_in.entry_count = kcat_pkg::COUNT_W'(used_ff);
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // miss: append at the end, or drop when the table is full
      if (do_append) begin
         priority if (used_ff < CW'(TABLE_DEPTH)) begin
            mem_we             = 1'b1;
            waddr              = used_ff[AW-1:0];
            wdata              = {acc_key, acc_val};
            used_in            = used_ff + CW'(1);
            load_rsp           = 1'b1;
            rsp_in.out_slot    = kcat_pkg::SLOT_W'(used_ff[AW-1:0]);
            rsp_in.out_key     = kcat_pkg::KEY_W'(acc_key);
            rsp_in.out_value   = kcat_pkg::VALUE_W'(acc_val);
            rsp_in.slot_valid  = 1'b1;
            rsp_in.entry_count = kcat_pkg::COUNT_W'(used_in);
         end else begin
            load_rsp           = 1'b1;
            rsp_in.dropped     = 1'b1;
            rsp_in.entry_count = kcat_pkg::COUNT_W'(used_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= CW'(TABLE_DEPTH), "entry count above depth")
   `ASSERT_IMPLY(a_busy_out_empty, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff, "result pending while busy")
   `ASSERT_IMPLY(a_search_idx, clock, reset, state_ff == ST_SEARCH, CW'(idx_ff) < used_ff, "search past last entry")
   `ASSERT_IMPLY(a_drop_full, clock, reset, rsp_valid_ff && rsp_ff.dropped, used_ff == CW'(TABLE_DEPTH), "drop with room left")
   `ASSERT_NEXT(a_search_start, clock, reset, q_pop && (q_cmd.kind == kcat_pkg::CMD_ACCUM) && (used_ff != '0), state_ff == ST_SEARCH, "accumulate skipped search")

endmodule

@@ hw/rtl/keyed_count_accumulator_table_top.sv @@
// keyed count accumulator table
// req channel: one word per command (req_valid/req_stall, req_data); op selects
// clear, accumulate key and value, read one slot, or no operation.
// rsp channel: exactly one result word per command, in command order
// (rsp_valid/rsp_stall, rsp_data).
// a front register decodes commands into a two-entry queue; the back end
// owns the table memory and walks the stored keys one per cycle.
// a result passes the front register, the queue and the result register; a read
// of a filled slot also passes the read state, and an accumulate into a
// non-empty table walks the search state until it hits a slot or misses.
// the back end takes a new command only from idle with the result register
// free, so one command at a time; reads and searches are bound by the single
// read port of the table memory.
// reset empties the table and the queue; no clearing pass is needed.
// when rsp_stall is high the result word holds, the back end waits before
// starting the next command, and the queue and front fill, then req_stall rises.
module keyed_count_accumulator_table_top #(
   parameter int TABLE_DEPTH = kcat_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = kcat_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS  = kcat_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kcat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kcat_pkg::rsp_type rsp_data
);

   logic              push;
   kcat_pkg::cmd_type push_cmd;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   kcat_pkg::cmd_type q_cmd;

   kcat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_full    (q_full)
   );

   kcat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd)
   );

   kcat_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
